// ----- rtl/mei_pkg.sv -----
// ============================================================================
// mei_pkg: shared types and constants of the modular exponentiation unit
// Holds the operation codes, the modulus reset value and the status bundle
// that the shared modular multiplier reports to the sequencer.
// ============================================================================
package mei_pkg;

    // Operation codes carried in the request's tuser bit.
    localparam logic CMD_POWER   = 1'b0;
    localparam logic CMD_INVERSE = 1'b1;

    // Modulus after reset: the Mersenne prime 2^61 - 1, cut to the element width.
    localparam logic [63:0] MOD_RESET = 64'h1FFF_FFFF_FFFF_FFFF;

    // Status of the shared modular multiplier.
    typedef struct packed {
        logic busy;   // a product is being formed
        logic done;   // one-cycle pulse: product is valid
    } mm_status_t;

endpackage

// ----- rtl/mei_mod_mul.sv -----
// ============================================================================
// mei_mod_mul: iterative modular multiplier
// Forms (x * y) mod m by MSB-first shift and add, one multiplier bit per
// cycle, with both reductions folded into one compare-and-select stage.
// ============================================================================
module mei_mod_mul #(
    parameter int ELEMENT_WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [ELEMENT_WIDTH-1:0] x,
    input  logic [ELEMENT_WIDTH-1:0] y,
    input  logic [ELEMENT_WIDTH-1:0] m,
    output logic [ELEMENT_WIDTH-1:0] product,
    output mei_pkg::mm_status_t      status
);
    import mei_pkg::*;

    localparam int W     = ELEMENT_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     x_reg;
    logic [W-1:0]     y_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [W+1:0] sum;
    logic [W+1:0] mod1;
    logic [W+1:0] mod2;
    logic [W+1:0] diff1;
    logic [W+1:0] diff2;

    // The operands stay below m, so 2*acc + x stays below 3m and at most
    // two multiples of m have to come off.
    always_comb
    begin
        mod1     = {2'b00, m};
        mod2     = {1'b0, m, 1'b0};
        sum      = {1'b0, acc_reg, 1'b0} + (y_reg[W-1] ? {2'b00, x_reg} : '0);
        diff1    = sum - mod1;
        diff2    = sum - mod2;
        if (sum >= mod2)
        begin
            acc_next = diff2[W-1:0];
        end
        else if (sum >= mod1)
        begin
            acc_next = diff1[W-1:0];
        end
        else
        begin
            acc_next = sum[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            x_reg   <= x;
            y_reg   <= y;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[W-2:0], 1'b0};
        end
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

`ifndef SYNTHESIS
    // A new product is never started over one that is still being formed.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("modular multiplier restarted while busy");

    // Completion follows a busy cycle.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("modular multiplier done without work");

    // A finished product is fully reduced.
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (acc_reg < m))
        else $error("modular product not reduced");
`endif

endmodule

// ----- rtl/modular_exponentiation_inverse_unit.sv -----
// ============================================================================
// modular_exponentiation_inverse_unit: modular power and Fermat inverse
// Raises an element to an exponent modulo a configured modulus, or to the
// modulus minus two to form the inverse in a prime field.
// ============================================================================
//
// Each request carries a base, an exponent and a one-bit command; each gives
// exactly one result, base to the exponent modulo the modulus register. With
// the inverse command the exponent is replaced by the modulus minus two (taken
// within ELEMENT_WIDTH bits), which is the multiplicative inverse when the
// modulus is prime. A zero exponent gives exactly 1, and otherwise a modulus
// of zero or one gives 0. The work is right-to-left square and multiply, and
// every product goes through one shared shift-and-add modular multiplier that
// handles one multiplier bit per clock. A request first reduces the base (one
// product time), then for each exponent bit below the highest set one spends a
// square, plus a multiply when the bit is set; the highest set bit spends only
// a multiply. A zero exponent or a modulus below two skips the multiplier and
// goes straight to the result.
// The unit takes one request at a time: s_tready is high only while it is
// idle. A finished result waits in the output register, so the next request
// may be taken before the previous result has been read. The modulus is
// written through cfg_we and cfg_wdata and must only change while idle.
//
module modular_exponentiation_inverse_unit #(
    parameter int ELEMENT_WIDTH = 64
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    // Configuration: modulus register.
    input  logic                                          cfg_we,
    input  logic [ELEMENT_WIDTH-1:0]                      cfg_wdata,
    // Request channel.
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // s_tdata fields from bit 0: base, exponent, zero padding to whole bytes.
    input  logic [((2*ELEMENT_WIDTH+7)/8)*8-1:0]          s_tdata,
    // s_tuser fields from bit 0: cmd.
    input  logic                                          s_tuser,
    // Result channel.
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // m_tdata fields from bit 0: result, zero padding to whole bytes.
    output logic [((ELEMENT_WIDTH+7)/8)*8-1:0]            m_tdata
);
    import mei_pkg::*;

    localparam int W      = ELEMENT_WIDTH;
    localparam int OUT_DW = ((W + 7) / 8) * 8;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RED   = 3'd1;  // base reduction
    localparam logic [2:0] S_CHECK = 3'd2;  // look at the next exponent bit
    localparam logic [2:0] S_MUL   = 3'd3;  // accumulator times square
    localparam logic [2:0] S_SQR   = 3'd4;  // square the running power
    localparam logic [2:0] S_DONE  = 3'd5;  // hand the result to the output

    logic [2:0]   state_reg, state_next;
    logic [W-1:0] mod_reg;
    logic [W-1:0] exp_reg, exp_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] sq_reg, sq_next;
    logic [W-1:0] res_reg;
    logic         out_valid_reg;

    logic         s_accept;
    logic         out_load;
    logic         in_cmd;
    logic [W-1:0] in_base;
    logic [W-1:0] in_exp;

    logic         mm_start;
    logic [W-1:0] mm_x;
    logic [W-1:0] mm_y;
    logic [W-1:0] mm_product;
    mm_status_t   mm_status;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_cmd   = s_tuser;
    assign in_base  = s_tdata[W-1:0];
    // The inverse uses modulus minus two, wrapping within the element width.
    assign in_exp   = (in_cmd == CMD_INVERSE) ? (mod_reg - W'(2)) : s_tdata[2*W-1:W];
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    mei_mod_mul #(
        .ELEMENT_WIDTH (W)
    ) u_mod_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .x       (mm_x),
        .y       (mm_y),
        .m       (mod_reg),
        .product (mm_product),
        .status  (mm_status)
    );

    // Sequencer: decides which product the shared multiplier forms next.
    always_comb
    begin
        state_next = state_reg;
        exp_next   = exp_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        mm_start   = 1'b0;
        mm_x       = sq_reg;
        mm_y       = sq_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    exp_next = in_exp;
                    if (in_exp == '0)
                    begin
                        // Zero exponent gives one, whatever the modulus.
                        acc_next   = W'(1);
                        state_next = S_DONE;
                    end
                    else if (mod_reg < W'(2))
                    begin
                        // No field to work in: every reduced value is zero.
                        acc_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Reducing the base is a product with one.
                        acc_next   = W'(1);
                        mm_start   = 1'b1;
                        mm_x       = W'(1);
                        mm_y       = in_base;
                        state_next = S_RED;
                    end
                end
            end

            S_RED:
            begin
                if (mm_status.done)
                begin
                    sq_next    = mm_product;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                mm_start = 1'b1;
                if (exp_reg[0])
                begin
                    mm_x       = acc_reg;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_SQR;
                end
            end

            S_MUL:
            begin
                if (mm_status.done)
                begin
                    acc_next = mm_product;
                    if (exp_reg[W-1:1] == '0)
                    begin
                        // Highest set bit used: the last square is not needed.
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mm_start   = 1'b1;
                        state_next = S_SQR;
                    end
                end
            end

            S_SQR:
            begin
                if (mm_status.done)
                begin
                    sq_next    = mm_product;
                    exp_next   = {1'b0, exp_reg[W-1:1]};
                    state_next = (exp_reg[W-1:1] == '0) ? S_DONE : S_CHECK;
                end
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            mod_reg       <= MOD_RESET[W-1:0];
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                mod_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg <= exp_next;
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        if (out_load)
        begin
            res_reg <= acc_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DW'(res_reg);

`ifndef SYNTHESIS
    // The multiplier is idle whenever a new request can be taken.
    a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !mm_status.busy)
        else $error("request taken while the multiplier is busy");

    // A result appears only after the sequencer has reached its last state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside the completion state");

    // Accumulator and running square stay reduced between exponent bits.
    a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> ((acc_reg < mod_reg) && (sq_reg < mod_reg)))
        else $error("exponentiation operands not reduced");

    // The multiplier only finishes while a product is awaited.
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mm_status.done |-> ((state_reg == S_RED) || (state_reg == S_MUL) ||
                            (state_reg == S_SQR)))
        else $error("unexpected product completion");
`endif

endmodule
